@@ src/pmt_pkg.sv @@
// Package with the shared sizes, types and state codes of the pointer tag table.
package pmt_pkg;

  localparam int unsigned IndexBits  = 10;
  localparam int unsigned TableDepth = 1 << IndexBits;
  localparam int unsigned WordW      = 64;
  localparam int unsigned SlotFieldW = 10;

  typedef logic [IndexBits-1:0] slot_t;
  typedef logic [WordW-1:0]     word_t;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_CHECK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_CMP
  } state_e;

  typedef struct packed {
    word_t tag_fp;
    word_t tag_addr;
  } tag_t;

  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    slot_t addr;
    tag_t  wdata;
  } store_req_t;

endpackage

@@ src/pmt_store.sv @@
// Tag memory with a zero-fill sweep after reset and a registered read.
module pmt_store import pmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output tag_t       rdata_o,
  output logic       ready_o
);

  tag_t  mem [TableDepth];
  tag_t  rdata_q;
  logic  clr_busy_q, clr_busy_d;
  slot_t clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + slot_t'(1);
      if (clr_cnt_q == slot_t'(TableDepth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // The sweep owns the write port until every entry holds zero.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

@@ src/pointer_mac_table.sv @@
// Top level of the pointer tag table: hashing, request sequencing and result register.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o   | op_i, fp_i, addr_i
//   out     | output    | out_valid_o / out_stall_i | match_o, slot_index_o
//
// Each item goes through accept, hash multiply with memory read, then compare and write-back.
// The single-port tag memory and the one-item sequencer keep a new item out until the last one is through.
// After reset the memory is swept to zero, one entry a cycle over all 1024 entries; no item is taken meanwhile.
// A finished result waits in the output register, so a new item can be accepted while it is stalled.
// An item that finds the output register still full and stalled waits in the compare step.
module pointer_mac_table import pmt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [WordW-1:0]      fp_i,
  input  logic [WordW-1:0]      addr_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  match_o,
  output logic [SlotFieldW-1:0] slot_index_o
);

  state_e     state_q, state_d;
  logic       in_accept;
  logic       out_free;
  logic       out_load;
  logic       store_ready;
  tag_t       rdata;
  store_req_t req;

  op_e        op_q;
  word_t      want_fp_q, want_addr_q;
  slot_t      hx_q;
  slot_t      hx_p3;
  slot_t      prod;
  slot_t      slot_d, slot_q;
  logic       hit;

  logic       out_valid_q, out_valid_d;
  logic       match_q;
  logic [SlotFieldW-1:0] slot_out_q;

  assign in_stall_o = (state_q != S_IDLE) || !store_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Only the low slot bits of the product matter, and they depend only on the low operand bits.
  assign hx_p3  = hx_q + slot_t'(3);
  assign prod   = hx_q * hx_p3;
  assign slot_d = prod;

  assign hit = (op_q == OP_CHECK) && (rdata.tag_fp == want_fp_q)
               && (rdata.tag_addr == want_addr_q);

  always_comb begin
    state_d        = state_q;
    out_load       = 1'b0;
    req.rd_en      = 1'b0;
    req.wr_en      = 1'b0;
    req.addr       = slot_q;
    req.wdata      = '{tag_fp: want_fp_q, tag_addr: want_addr_q};
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        req.rd_en = 1'b1;
        req.addr  = slot_d;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (out_free) begin
          out_load  = 1'b1;
          req.wr_en = (op_q == OP_RECORD);
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q        <= op_e'(op_i);
      want_fp_q   <= fp_i + word_t'(1);
      want_addr_q <= addr_i + word_t'(1);
      hx_q        <= addr_i[IndexBits-1:0] ^ addr_i[32 +: IndexBits];
    end
    if (state_q == S_HASH) begin
      slot_q <= slot_d;
    end
    if (out_load) begin
      match_q    <= hit;
      slot_out_q <= SlotFieldW'(slot_q);
    end
  end

  pmt_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rdata),
    .ready_o (store_ready)
  );

  assign out_valid_o  = out_valid_q;
  assign match_o      = match_q;
  assign slot_index_o = slot_out_q;

  a_no_rd_wr_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.rd_en && req.wr_en))
    else $error("tag memory read and write issued together");

  a_accept_goes_to_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_HASH))
    else $error("accepted item did not enter the hash step");

  a_load_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("finished item did not reach the output register");

  a_no_accept_during_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !store_ready |-> !in_accept && (state_q == S_IDLE))
    else $error("item taken while the tag memory is being cleared");

  a_record_never_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (op_q == OP_RECORD) |=> !match_q)
    else $error("record item reported a match");

endmodule

@@ dv/pmt_tb_pkg.sv @@
// Scoreboard for the pointer tag table: its own copy of the tag store and the queue of expected results.
package pmt_tb_pkg;
  import pmt_pkg::*;

  class tag_table_scoreboard;
    word_t                 fp_tags[TableDepth];
    word_t                 addr_tags[TableDepth];
    bit                    hit_q[$];
    logic [SlotFieldW-1:0] slot_q[$];
    int                    errors;

    function new();
      foreach (fp_tags[i]) begin
        fp_tags[i]   = '0;
        addr_tags[i] = '0;
      end
      errors = 0;
    endfunction

    // Fold the upper half of the address into the lower half, then h * (h + 3) mod 2^64.
    static function slot_t slot_of(word_t a);
      word_t h;
      h = a ^ (a >> 32);
      h = h * (h + 64'd3);
      return h[IndexBits-1:0];
    endfunction

    function void note_request(op_e op, word_t fp, word_t addr);
      slot_t slot;
      bit    hit;
      slot = slot_of(addr);
      hit  = 1'b0;
      if (op == OP_RECORD) begin
        fp_tags[slot]   = fp + 64'd1;
        addr_tags[slot] = addr + 64'd1;
      end else begin
        hit = (fp_tags[slot] == fp + 64'd1) && (addr_tags[slot] == addr + 64'd1);
      end
      hit_q.push_back(hit);
      slot_q.push_back(SlotFieldW'(slot));
    endfunction

    function void check_result(logic hit, logic [SlotFieldW-1:0] slot, longint unsigned now);
      bit                    want_hit;
      logic [SlotFieldW-1:0] want_slot;
      if (hit_q.size() == 0) begin
        $display("%0t: result with nothing expected (match %0b slot %0d)", now, hit, slot);
        errors++;
        return;
      end
      want_hit  = hit_q.pop_front();
      want_slot = slot_q.pop_front();
      if (hit !== want_hit) begin
        $display("%0t: match expected %0b actual %b", now, want_hit, hit);
        errors++;
      end
      if (slot !== want_slot) begin
        $display("%0t: slot_index expected %0d actual %0d", now, want_slot, slot);
        errors++;
      end
    endfunction

    function int pending();
      return hit_q.size();
    endfunction
  endclass

endpackage

@@ dv/tb.sv @@
// Top-level testbench of the pointer tag table: clock, reset, request driver and result monitor.
module tb import pmt_pkg::*, pmt_tb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    word_t fp;
    word_t addr;
  } pair_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  op_i        = OP_RECORD;
  logic [WordW-1:0]      fp_i        = '0;
  logic [WordW-1:0]      addr_i      = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  match_o;
  logic [SlotFieldW-1:0] slot_index_o;

  tag_table_scoreboard sb = new();
  bit                  calm = 1'b0;
  pair_t               book[$];

  pointer_mac_table uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly no pause, some short ones, a few long ones; none during calm stretches.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(35, 8);
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t pointer_like();
    return {32'h0000_7fff, $urandom} & ~64'd7;
  endfunction

  // Another address that lands in the same table slot.
  function automatic word_t colliding_addr(word_t a);
    word_t c;
    do c = $urandom_range(1) ? rand_word() : pointer_like();
    while (c == a || tag_table_scoreboard::slot_of(c) != tag_table_scoreboard::slot_of(a));
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item was taken.
  task automatic send_item(op_e op, word_t fp, word_t addr);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    fp_i       <= fp;
    addr_i     <= addr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, fp, addr);
    @(negedge clk_i);
  endtask

  task automatic record_pair(word_t fp, word_t addr);
    pair_t p;
    send_item(OP_RECORD, fp, addr);
    p.fp   = fp;
    p.addr = addr;
    book.push_back(p);
    if (book.size() > 48) void'(book.pop_front());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(match_o, slot_index_o, $time);
  end

  initial begin
    int n;
    @(negedge clk_i);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(negedge clk_i);
    end
  end

  initial begin
    word_t a, b, c, f;
    int    sel, idx;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Both fields all ones wrap to zero and match an untouched slot.
    send_item(OP_CHECK, '1, '1);
    send_item(OP_CHECK, '0, '0);
    record_pair('0, '0);
    send_item(OP_CHECK, '0, '0);
    record_pair('1, '1);
    send_item(OP_CHECK, '1, '1);
    record_pair('1, 64'd5);
    send_item(OP_CHECK, '1, 64'd5);
    send_item(OP_CHECK, '0, 64'd5);
    record_pair(64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000);
    send_item(OP_CHECK, 64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000);
    record_pair(64'h0123_4567_89ab_cdef, 64'hffff_ffff_0000_0000);
    send_item(OP_CHECK, 64'h0123_4567_89ab_cdef, 64'hffff_ffff_0000_0000);
    // A later record to a colliding address takes the slot over.
    a = pointer_like();
    b = colliding_addr(a);
    f = rand_word();
    record_pair(f, a);
    send_item(OP_CHECK, f, a);
    record_pair(~f, b);
    send_item(OP_CHECK, f, a);
    send_item(OP_CHECK, ~f, b);
    // Same slot, but either the stored address or the stored fingerprint differs.
    c = colliding_addr(b);
    send_item(OP_CHECK, ~f, c);
    send_item(OP_CHECK, f, b);

    for (int i = 0; i < 1900; i++) begin
      calm = (i % 400) >= 340;
      sel  = $urandom_range(99);
      idx  = (book.size() == 0) ? 0 : $urandom_range(book.size() - 1);
      if (book.size() == 0 || sel < 30) begin
        record_pair(rand_word(), $urandom_range(1) ? rand_word() : pointer_like());
      end else if (sel < 60) begin
        send_item(OP_CHECK, book[idx].fp, book[idx].addr);
      end else if (sel < 70) begin
        send_item(OP_CHECK, book[idx].fp ^ (64'd1 << $urandom_range(63)), book[idx].addr);
      end else if (sel < 74) begin
        send_item(OP_CHECK, '1, '1);
      end else if (sel < 86) begin
        record_pair(rand_word(), colliding_addr(book[idx].addr));
      end else if (sel < 93) begin
        send_item(OP_CHECK, book[idx].fp, colliding_addr(book[idx].addr));
      end else begin
        send_item($urandom_range(1) ? OP_CHECK : OP_RECORD, rand_word(), rand_word());
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
